// ===== sv/fibonacci_decimal_digits_assert.svh =====
// assertion macros for the fibonacci decimal digits block
// used by the top level; no other dependencies
`ifndef FIBONACCI_DECIMAL_DIGITS_ASSERT_SVH
`define FIBONACCI_DECIMAL_DIGITS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FDD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("fdd: same-cycle check failed");
// next-cycle implication
`define FDD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("fdd: next-cycle check failed");
`else
`define FDD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define FDD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== sv/fdd_pkg.sv =====
// shared types and constants for the fibonacci decimal digits block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fdd_pkg;

	localparam int DIGIT_BITS       = 4;
	localparam int WORD_INDEX_BITS  = 3;
	localparam int DIGITS_WORD_BITS = 64;
	localparam logic [DIGIT_BITS-1:0] BCD_SIX = 4'd6;

	// carries reported by the word adder
	typedef struct packed {
		logic word_carry;
		logic top_carry;
	} carry_t;

endpackage

`default_nettype wire

// ===== sv/fdd_pair_ram.sv =====
// synchronous memory holding the older/newer digit pair, one word per entry
// depends on nothing; one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module fdd_pair_ram #(
	parameter int DEPTH     = 8,
	parameter int ADDR_BITS = 3,
	parameter int DATA_BITS = 128
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [DATA_BITS-1:0] wdata,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/fdd_word_adder.sv =====
// one word of decimal addition: bias by six, binary add, correct nibbles
// depends on fdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdd_word_adder #(
	parameter int WORD_DIGITS = 16,
	parameter int TOP_DIGIT   = 15
) (
	input  wire logic [WORD_DIGITS*fdd_pkg::DIGIT_BITS-1:0] a,
	input  wire logic [WORD_DIGITS*fdd_pkg::DIGIT_BITS-1:0] b,
	input  wire logic                                      cin,
	input  wire logic                                      is_last,
	output logic      [WORD_DIGITS*fdd_pkg::DIGIT_BITS-1:0] sum,
	output fdd_pkg::carry_t                                carries
);

	localparam int DB = fdd_pkg::DIGIT_BITS;
	localparam int WB = WORD_DIGITS * DB;

	logic [WB-1:0] six_pat;
	logic [WB:0]   biased;
	logic [WB:0]   total;
	logic [WB:0]   flips;

	always_comb begin
		for (int k = 0; k < WORD_DIGITS; k++) begin
			six_pat[k*DB +: DB] = fdd_pkg::BCD_SIX;
		end
		// digits are at most nine, so the bias never carries between nibbles
		biased = {1'b0, a} + {1'b0, six_pat};
		total  = biased + {1'b0, b} + {{WB{1'b0}}, cin};
		// bit 4k+4 of flips is the decimal carry out of digit k
		flips  = biased ^ {1'b0, b} ^ total;
		for (int k = 0; k < WORD_DIGITS; k++) begin
			if (is_last && (k > TOP_DIGIT)) begin
				sum[k*DB +: DB] = '0;
			end else if (flips[k*DB+DB]) begin
				sum[k*DB +: DB] = total[k*DB +: DB];
			end else begin
				sum[k*DB +: DB] = total[k*DB +: DB] - fdd_pkg::BCD_SIX;
			end
		end
		carries.word_carry = flips[WB];
		carries.top_carry  = flips[TOP_DIGIT*DB+DB];
	end

endmodule

`default_nettype wire

// ===== sv/fibonacci_decimal_digits.sv =====
// top level: decimal fibonacci engine over a word-wide pair memory
// depends on fdd_pkg, fdd_pair_ram, fdd_word_adder, fibonacci_decimal_digits_assert.svh
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+---------------------------
//  input   | index_n                                            | start high, busy low
//  result  | word_index, digits_word, overflow_flag, last_word  | result_strobe, one cycle
//
// sequence: an index n first seeds the memory word by word, then runs max(n-1,0)
//   addition passes over all words plus a drain step when n is above one,
//   then streams the words out
// the pace is set by the memory: one word read and one written a cycle
// reset: asynchronous, active low; it clears the sequencer, the memory is seeded per item
// stalls: none; the receiver takes each word in the cycle its strobe is high
`timescale 1ns / 1ps
`default_nettype none

`include "fibonacci_decimal_digits_assert.svh"

module fibonacci_decimal_digits #(
	parameter int HALF_DIGITS = 64,
	parameter int WORD_DIGITS = 16,
	parameter int INDEX_BITS  = 10
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [INDEX_BITS-1:0]                 index_n,
	output logic                                       result_strobe,
	output logic [fdd_pkg::WORD_INDEX_BITS-1:0]        word_index,
	output logic [fdd_pkg::DIGITS_WORD_BITS-1:0]       digits_word,
	output logic                                       overflow_flag,
	output logic                                       last_word
);

	localparam int DB          = fdd_pkg::DIGIT_BITS;
	localparam int WIB         = fdd_pkg::WORD_INDEX_BITS;
	localparam int DWB         = fdd_pkg::DIGITS_WORD_BITS;
	localparam int TOTAL       = 2 * HALF_DIGITS;
	localparam int NUM_WORDS   = (TOTAL + WORD_DIGITS - 1) / WORD_DIGITS;
	localparam int ADDR_BITS   = $clog2(NUM_WORDS);
	localparam int WB          = WORD_DIGITS * DB;
	localparam int TOP_DIGIT   = (TOTAL - 1) % WORD_DIGITS;
	localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(NUM_WORDS - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INIT = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic [ADDR_BITS-1:0]  addr_q;      // read / seed address
	logic [INDEX_BITS-1:0] steps_q;     // addition passes still to issue
	logic                  issuing_q;   // reads still being issued in add or emit
	logic                  n_zero_q;    // result is the older value
	logic                  sticky_q;
	logic                  carry_q;     // decimal carry between words of one pass

	// read pipeline: add write-back and emit stage
	logic                  v_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic                  ev_s1;
	logic [ADDR_BITS-1:0]  eaddr_s1;

	// memory port signals
	logic                  mem_we;
	logic [ADDR_BITS-1:0]  mem_waddr;
	logic [2*WB-1:0]       mem_wdata;
	logic [2*WB-1:0]       mem_rdata;
	logic [WB-1:0]         rd_older;
	logic [WB-1:0]         rd_newer;

	// adder
	logic [WB-1:0]         add_sum;
	logic                  add_cin;
	logic                  add_last;
	fdd_pkg::carry_t       add_carries;

	logic                  accept;
	logic [ADDR_BITS-1:0]  addr_next;
	logic [WB-1:0]         seed_newer;

	// output formatting
	logic [WB-1:0]            sel_word;
	logic [WB+DWB-1:0]        sel_wide;
	logic [ADDR_BITS+WIB-1:0] eaddr_wide;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign addr_next = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;

	assign rd_older = mem_rdata[2*WB-1:WB];
	assign rd_newer = mem_rdata[WB-1:0];

	// word 0 is seeded with fib(1) in the newer half
	assign seed_newer = (addr_q == '0) ? {{(WB-1){1'b0}}, 1'b1} : '0;

	// carry restarts at word 0 of every pass
	assign add_cin  = (addr_s1 == '0) ? 1'b0 : carry_q;
	assign add_last = (addr_s1 == LAST_ADDR);

	fdd_word_adder #(
		.WORD_DIGITS (WORD_DIGITS),
		.TOP_DIGIT   (TOP_DIGIT)
	) u_adder (
		.a       (rd_older),
		.b       (rd_newer),
		.cin     (add_cin),
		.is_last (add_last),
		.sum     (add_sum),
		.carries (add_carries)
	);

	// write port: seed pass, or write-back of the word read last cycle
	always_comb begin
		if (state_q == ST_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = {{WB{1'b0}}, seed_newer};
		end else begin
			mem_we    = v_s1;
			mem_waddr = addr_s1;
			mem_wdata = {rd_newer, add_sum};
		end
	end

	// reads run one word ahead of writes, so a pass never reads the entry
	// being written; the seed and the last write-back land before the next read
	fdd_pair_ram #(
		.DEPTH     (NUM_WORDS),
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (2 * WB)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			addr_q    <= '0;
			steps_q   <= '0;
			issuing_q <= 1'b0;
			n_zero_q  <= 1'b0;
			sticky_q  <= 1'b0;
			carry_q   <= 1'b0;
			v_s1      <= 1'b0;
			ev_s1     <= 1'b0;
		end else begin
			v_s1  <= 1'b0;
			ev_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_INIT;
						addr_q   <= '0;
						n_zero_q <= (index_n == '0);
						steps_q  <= (index_n > INDEX_BITS'(1)) ? index_n - 1'b1 : '0;
						sticky_q <= 1'b0;
					end
				end
				ST_INIT: begin
					addr_q <= addr_next;
					if (addr_q == LAST_ADDR) begin
						issuing_q <= 1'b1;
						state_q   <= (steps_q != '0) ? ST_ADD : ST_EMIT;
					end
				end
				ST_ADD: begin
					if (issuing_q) begin
						v_s1   <= 1'b1;
						addr_q <= addr_next;
						if (addr_q == LAST_ADDR) begin
							steps_q <= steps_q - 1'b1;
							if (steps_q == INDEX_BITS'(1)) begin
								issuing_q <= 1'b0;
							end
						end
					end else begin
						// last write-back goes in this cycle
						state_q   <= ST_EMIT;
						addr_q    <= '0;
						issuing_q <= 1'b1;
					end
					if (v_s1) begin
						carry_q <= add_carries.word_carry;
						if (add_last && add_carries.top_carry) begin
							sticky_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (issuing_q) begin
						ev_s1  <= 1'b1;
						addr_q <= addr_next;
						if (addr_q == LAST_ADDR) begin
							issuing_q <= 1'b0;
						end
					end else begin
						// final word is on the ports this cycle
						state_q <= ST_IDLE;
						addr_q  <= '0;
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					issuing_q <= 1'b0;
				end
			endcase
		end
	end

	// stage addresses travel with the valid bits
	always_ff @(posedge clk) begin
		addr_s1  <= addr_q;
		eaddr_s1 <= addr_q;
	end

	// result formatting
	assign sel_word   = n_zero_q ? rd_older : rd_newer;
	assign sel_wide   = {{DWB{1'b0}}, sel_word};
	assign eaddr_wide = {{WIB{1'b0}}, eaddr_s1};

	assign result_strobe = ev_s1;
	assign word_index    = eaddr_wide[WIB-1:0];
	assign digits_word   = sel_wide[DWB-1:0];
	assign overflow_flag = sticky_q;
	assign last_word     = (eaddr_s1 == LAST_ADDR);

	// checks
	`FDD_ASSERT_IMP(a_strobe_in_emit, clk, arst_n, result_strobe, state_q == ST_EMIT)
	`FDD_ASSERT_IMP(a_writeback_in_add, clk, arst_n, v_s1, state_q == ST_ADD)
	`FDD_ASSERT_IMP(a_idle_quiet, clk, arst_n, !busy, !v_s1 && !ev_s1)
	`FDD_ASSERT_NXT(a_words_contiguous, clk, arst_n, result_strobe && !last_word, result_strobe)
	`FDD_ASSERT_NXT(a_done_after_last, clk, arst_n, result_strobe && last_word, !busy)

endmodule

`default_nettype wire
